// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the reassembly tracker RTL.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`endif

// ----- rtl/core/frt_pkg.sv -----
// Types and constants for the fragment reassembly tracker.
// No dependencies.
package frt_pkg;
	localparam logic [7:0] TYPE_WHOLE = 8'hBB;
	localparam logic [7:0] TYPE_FRAG = 8'h1B;
	localparam logic [15:0] FRAG_HDR_LEN = 16'd8;
	localparam logic [15:0] EXPIRY_RESET = 16'd60;
	localparam logic [2:0] ST_WHOLE = 3'd0;
	localparam logic [2:0] ST_STORED = 3'd1;
	localparam logic [2:0] ST_COMPLETE = 3'd2;
	localparam logic [2:0] ST_BAD_INDEX = 3'd3;
	localparam logic [2:0] ST_UNKNOWN = 3'd4;
	localparam logic [2:0] ST_FULL = 3'd5;
	localparam logic [2:0] ST_SWEEP = 3'd6;
	localparam logic [2:0] ST_EMPTY = 3'd7;
	localparam logic [1:0] OP_IMM = 2'd0;
	localparam logic [1:0] OP_FRAG = 2'd1;
	localparam logic [1:0] OP_SWEEP = 2'd2;
	typedef struct packed {
		logic [1:0] op;
		logic [2:0] status;
		logic [31:0] now;
		logic [15:0] payload;
		logic [31:0] id;
		logic [15:0] idx;
		logic [7:0] count;
		logic [23:0] bytes;
	} frt_cmd_t;
endpackage

// ----- rtl/core/frt_front.sv -----
// Front end: accepts items, classifies them and queues commands.
// Depends on frt_pkg.
module frt_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic req_type,
	input logic [31:0] now_seconds,
	input logic [15:0] datagram_len,
	input logic [7:0] type_byte,
	input logic [31:0] bundle_id,
	input logic [15:0] fragment_index,
	input logic [7:0] fragment_count,
	output logic full,
	output logic empty,
	output frt_pkg::frt_cmd_t head,
	input logic pop
);
	import frt_pkg::*;
	frt_cmd_t cmd;
	frt_cmd_t fifo_q [2];
	logic wr_q, rd_q;
	logic [1:0] cnt_q;
	always_comb begin
		cmd = '0;
		cmd.now = now_seconds;
		cmd.id = bundle_id;
		cmd.idx = fragment_index;
		cmd.count = fragment_count;
		cmd.payload = datagram_len - FRAG_HDR_LEN;
		cmd.op = OP_IMM;
		if (req_type) begin
			cmd.op = OP_SWEEP;
		end else if (datagram_len == '0) begin
			cmd.status = ST_EMPTY;
		end else if (type_byte == TYPE_WHOLE) begin
			cmd.status = ST_WHOLE;
			cmd.bytes = {8'd0, datagram_len - 16'd1};
		end else if (type_byte == TYPE_FRAG && datagram_len >= FRAG_HDR_LEN) begin
			cmd.op = OP_FRAG;
		end else begin
			cmd.status = ST_UNKNOWN;
		end
	end
	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign head = fifo_q[rd_q];
	always_ff @(posedge clk) begin
		if (in_valid && !full) fifo_q[wr_q] <= cmd;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (in_valid && !full) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			cnt_q <= cnt_q + {1'b0, in_valid && !full} - {1'b0, pop};
		end
	end
endmodule

// ----- rtl/core/frt_back.sv -----
// Back end: table lookup, bitmap and length store update, sweeps.
// Depends on frt_pkg.
module frt_back #(
	parameter int TABLE_ENTRIES = 8,
	parameter int MAX_FRAGMENTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic empty,
	input frt_pkg::frt_cmd_t head,
	output logic pop,
	input logic [15:0] expiry_seconds,
	output logic done,
	output logic [2:0] status,
	output logic [31:0] result_bundle_id,
	output logic [23:0] bundle_bytes,
	output logic [3:0] expired_count,
	output logic idle
);
	import frt_pkg::*;
	localparam int EW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int FW = $clog2(MAX_FRAGMENTS);
	localparam int CW = $clog2(MAX_FRAGMENTS + 1);
	localparam int SW = $clog2(TABLE_ENTRIES + 1);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_LOOK = 3'd1;
	localparam logic [2:0] S_READ = 3'd2;
	localparam logic [2:0] S_UPD = 3'd3;
	localparam logic [2:0] S_SWEEP = 3'd4;

	logic [2:0] state_q;
	frt_cmd_t cmd_q;
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [31:0] id_q [TABLE_ENTRIES];
	logic [CW-1:0] exp_q [TABLE_ENTRIES];
	logic [CW-1:0] rcv_q [TABLE_ENTRIES];
	logic [23:0] sum_q [TABLE_ENTRIES];
	logic [31:0] expt_q [TABLE_ENTRIES];
	logic [MAX_FRAGMENTS-1:0] seen_q [TABLE_ENTRIES];
	logic [15:0] len_mem [TABLE_ENTRIES * (1 << FW)];
	logic [15:0] len_rd_q;
	logic [EW-1:0] ent_q;
	logic hit_seen_q;
	logic [EW-1:0] scan_q;
	logic [SW-1:0] freed_q;

	logic hit, have_free;
	logic [EW-1:0] hit_e, free_e;
	logic [CW-1:0] cnt_sat;
	logic [FW-1:0] idx_n;
	logic idx_ok;
	logic [23:0] new_sum;
	logic [CW-1:0] new_rcv;

	always_comb begin
		hit = 1'b0;
		have_free = 1'b0;
		hit_e = '0;
		free_e = '0;
		for (int e = TABLE_ENTRIES - 1; e >= 0; e--) begin
			if (valid_q[e] && id_q[e] == cmd_q.id) begin
				hit = 1'b1;
				hit_e = EW'(e);
			end
			if (!valid_q[e]) begin
				have_free = 1'b1;
				free_e = EW'(e);
			end
		end
	end
	assign cnt_sat = ({8'd0, cmd_q.count} > 16'(MAX_FRAGMENTS)) ?
		CW'(MAX_FRAGMENTS) : CW'(cmd_q.count);
	assign idx_n = cmd_q.idx[FW-1:0];
	assign idx_ok = {16'd0, cmd_q.idx} < 32'(exp_q[ent_q]);
	assign new_sum = sum_q[ent_q] - (hit_seen_q ? {8'd0, len_rd_q} : 24'd0)
		+ {8'd0, cmd_q.payload};
	assign new_rcv = rcv_q[ent_q] + (hit_seen_q ? CW'(0) : CW'(1));
	assign pop = state_q == S_IDLE && !empty;
	assign idle = state_q == S_IDLE && empty;

	always_ff @(posedge clk) begin
		if (pop) cmd_q <= head;
		if (state_q == S_READ) begin
			len_rd_q <= len_mem[{ent_q, idx_n}];
			hit_seen_q <= seen_q[ent_q][idx_n];
		end
		if (state_q == S_UPD && idx_ok) len_mem[{ent_q, idx_n}] <= cmd_q.payload;
		if (state_q == S_LOOK && !hit && have_free) begin
			id_q[free_e] <= cmd_q.id;
			exp_q[free_e] <= cnt_sat;
			rcv_q[free_e] <= '0;
			sum_q[free_e] <= '0;
			expt_q[free_e] <= cmd_q.now + {16'd0, expiry_seconds};
			seen_q[free_e] <= '0;
		end
		if (state_q == S_UPD && idx_ok) begin
			sum_q[ent_q] <= new_sum;
			rcv_q[ent_q] <= new_rcv;
			seen_q[ent_q][idx_n] <= 1'b1;
		end
		status <= cmd_q.status;
		result_bundle_id <= '0;
		bundle_bytes <= '0;
		expired_count <= '0;
		if (state_q == S_IDLE) begin
			status <= head.status;
			bundle_bytes <= head.bytes;
		end
		if (state_q == S_LOOK && !hit && !have_free) begin
			status <= ST_FULL;
			result_bundle_id <= cmd_q.id;
		end
		if (state_q == S_UPD) begin
			result_bundle_id <= cmd_q.id;
			if (!idx_ok) status <= ST_BAD_INDEX;
			else if (new_rcv == exp_q[ent_q]) begin
				status <= ST_COMPLETE;
				bundle_bytes <= new_sum;
			end else status <= ST_STORED;
		end
		if (state_q == S_SWEEP) begin
			status <= ST_SWEEP;
			expired_count <= 4'(freed_q + SW'(valid_q[scan_q] &&
				cmd_q.now > expt_q[scan_q]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= '0;
			ent_q <= '0;
			scan_q <= '0;
			freed_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						if (head.op == OP_FRAG) state_q <= S_LOOK;
						else if (head.op == OP_SWEEP) begin
							state_q <= S_SWEEP;
							scan_q <= '0;
							freed_q <= '0;
						end else done <= 1'b1;
					end
				end
				S_LOOK: begin
					if (hit) begin
						ent_q <= hit_e;
						state_q <= S_READ;
					end else if (have_free) begin
						ent_q <= free_e;
						valid_q[free_e] <= 1'b1;
						state_q <= S_READ;
					end else begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_READ: state_q <= S_UPD;
				S_UPD: begin
					if (idx_ok && new_rcv == exp_q[ent_q]) valid_q[ent_q] <= 1'b0;
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				S_SWEEP: begin
					if (valid_q[scan_q] && cmd_q.now > expt_q[scan_q]) begin
						valid_q[scan_q] <= 1'b0;
						freed_q <= freed_q + SW'(1);
					end
					scan_q <= scan_q + EW'(1);
					if (32'(scan_q) == 32'(TABLE_ENTRIES - 1)) begin
						done <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ----- rtl/core/fragment_reassembly_tracker.sv -----
// Top level of the fragment reassembly tracker: APB register, front, back.
// Depends on frt_pkg, frt_front, frt_back, assert_macros.svh.
// An item is taken when start is high and busy low; its single result shows on
// status and the other result ports for one cycle with done high, and the
// receiver cannot stall it. Headers that need no table access finish as they
// leave the queue; fragments pass through lookup, bitmap and length read and
// update, or end after the lookup when the table is full; a sweep has the back
// end walk one table entry a cycle.
// A two-deep command queue lets the front accept while the back works.
`include "assert_macros.svh"
module fragment_reassembly_tracker #(
	parameter int TABLE_ENTRIES = 8,
	parameter int MAX_FRAGMENTS = 256
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic req_type,
	input logic [31:0] now_seconds,
	input logic [15:0] datagram_len,
	input logic [7:0] type_byte,
	input logic [31:0] bundle_id,
	input logic [15:0] fragment_index,
	input logic [7:0] fragment_count,
	output logic done,
	output logic [2:0] status,
	output logic [31:0] result_bundle_id,
	output logic [23:0] bundle_bytes,
	output logic [3:0] expired_count,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	import frt_pkg::*;
	logic [15:0] expiry_q;
	logic q_full, q_empty, pop, idle;
	frt_cmd_t head;

	assign pready = 1'b1;
	assign prdata = (paddr == 2'd0) ? {16'd0, expiry_q} : 32'd0;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) expiry_q <= EXPIRY_RESET;
		else if (psel && penable && pwrite && paddr == 2'd0) expiry_q <= pwdata[15:0];
	end
	assign busy = q_full;

	frt_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start),
		.req_type(req_type), .now_seconds(now_seconds), .datagram_len(datagram_len),
		.type_byte(type_byte), .bundle_id(bundle_id), .fragment_index(fragment_index),
		.fragment_count(fragment_count), .full(q_full), .empty(q_empty),
		.head(head), .pop(pop)
	);
	frt_back #(.TABLE_ENTRIES(TABLE_ENTRIES), .MAX_FRAGMENTS(MAX_FRAGMENTS)) u_back (
		.clk(clk), .arst_n(arst_n), .empty(q_empty), .head(head), .pop(pop),
		.expiry_seconds(expiry_q), .done(done), .status(status),
		.result_bundle_id(result_bundle_id), .bundle_bytes(bundle_bytes),
		.expired_count(expired_count), .idle(idle)
	);

	`ASSERT_IMPL(a_pop_nonempty, clk, arst_n, pop, !q_empty)
	`ASSERT_IMPL(a_sweep_fields, clk, arst_n, done && status == ST_SWEEP,
		result_bundle_id == 32'd0 && bundle_bytes == 24'd0)
	`ASSERT_NEXT(a_done_pulse, clk, arst_n, done && idle, !done)
endmodule
